/* design/qbn_pkg.sv */
// ----------------------------------------------------------------------------
// qbn_pkg
// Shared types, constants and helpers for the quantized batch norm block.
// ----------------------------------------------------------------------------
package qbn_pkg;

   localparam int MAX_CHANNELS_DEF = 256;
   localparam int FRAC_BITS_DEF    = 16;

   // pipeline depth from the coefficient read to the result register
   localparam int STAGES = 7;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam int WIDE_W = 68;

   localparam logic [31:0] SCALE_ONE = 32'h0001_0000;
   localparam logic [7:0]  BYTE_MAX  = 8'd255;

   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IN_ZERO_PT       = 3'd0,
      CSR_OUT_ZERO_PT      = 3'd1,
      CSR_IN_SCALE         = 3'd2,
      CSR_OUTPUT_INV_SCALE = 3'd3,
      CSR_CAFFE_MODE       = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] mean;
      logic signed [31:0] var_inv;
      logic signed [31:0] gamma;
      logic signed [31:0] beta;
   } coef_type;

   typedef struct packed {
      logic [7:0]  in_zero_pt;
      logic [7:0]  out_zero_pt;
      logic [31:0] in_scale;
      logic [31:0] output_inv_scale;
      logic        caffe_mode;
   } cfg_type;

   localparam logic signed [WIDE_W-1:0] S32_MAX = WIDE_W'(64'sd2147483647);
   localparam logic signed [WIDE_W-1:0] S32_MIN = -(WIDE_W'(64'sd2147483648));

   function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic signed [31:0] r;
      priority if (v > S32_MAX) begin
         r = 32'sh7fff_ffff;
      end else if (v < S32_MIN) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

/* design/qbn_if.sv */
// ----------------------------------------------------------------------------
// qbn_if
// Request and response channel interfaces, valid/ready handshake.
// ----------------------------------------------------------------------------
interface qbn_req_if;
   logic               valid;
   logic               ready;
   logic               mode;
   logic [7:0]         channel;
   logic signed [31:0] mean_coef;
   logic signed [31:0] var_inv_coef;
   logic signed [31:0] gamma_coef;
   logic signed [31:0] beta_coef;
   logic [7:0]         sample;
   logic               last_in;

   modport source (
      output valid, mode, channel, mean_coef, var_inv_coef, gamma_coef, beta_coef,
             sample, last_in,
      input  ready
   );
   modport sink (
      input  valid, mode, channel, mean_coef, var_inv_coef, gamma_coef, beta_coef,
             sample, last_in,
      output ready
   );
endinterface

interface qbn_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] value;
   logic       last_out;

   modport source (
      output valid, value, last_out,
      input  ready
   );
   modport sink (
      input  valid, value, last_out,
      output ready
   );
endinterface

/* design/qbn_ram.sv */
// ----------------------------------------------------------------------------
// qbn_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module qbn_ram #(
   parameter int WIDTH  = 128,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/qbn_ctrl.sv */
// ----------------------------------------------------------------------------
// qbn_ctrl
// Valid tracking and per-stage load enables for the datapath pipeline.
// ----------------------------------------------------------------------------
module qbn_ctrl import qbn_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic              out_ready,
   output logic [STAGES-1:0] load,
   output logic              out_valid
);

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] rdy;

   // a stage can take new data when empty or when its beat moves on
   always_comb begin
      rdy[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
   end

   always_comb begin
      valid_in[0] = rdy[0] ? push : valid_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         valid_in[k] = rdy[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign load      = rdy;
   assign out_valid = valid_ff[STAGES-1];

endmodule

/* design/qbn_dpath.sv */
// ----------------------------------------------------------------------------
// qbn_dpath
// Dequantize, normalize and requantize pipeline.
// ----------------------------------------------------------------------------
module qbn_dpath import qbn_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic [STAGES-1:0] load,
   input  cfg_type           cfg,
   input  logic [7:0]        sample,
   input  logic              last_in,
   input  logic              in_range,
   input  coef_type          coef,
   output logic [7:0]        value,
   output logic              last_out
);

   localparam logic signed [WIDE_W-1:0] HALF = WIDE_W'(64'sd1 <<< (FRAC_BITS - 1));

   // stage 0: sample minus zero point, times input scale
   logic signed [8:0]  d;
   logic signed [41:0] prod_x;
   logic signed [41:0] s1_prod_ff;
   logic               s1_in_range_ff;
   logic               s1_last_ff;

   assign d      = $signed({1'b0, sample}) - $signed({1'b0, cfg.in_zero_pt});
   assign prod_x = 42'(d) * 42'($signed({1'b0, cfg.in_scale}));

   always_ff @(posedge clock) begin
      if (load[0]) begin
         s1_prod_ff     <= prod_x;
         s1_in_range_ff <= in_range;
         s1_last_ff     <= last_in;
      end
   end

   // stage 1: coefficient word arrives from memory
   coef_type           c1;
   logic signed [31:0] x1;
   logic signed [31:0] s2_x_ff;
   logic signed [63:0] s2_ga_ff;
   logic signed [63:0] s2_gm_ff;
   logic signed [31:0] s2_var_inv_ff;
   logic signed [31:0] s2_mean_ff;
   logic signed [31:0] s2_beta_ff;
   logic               s2_last_ff;

   // channels past the table read as all-zero coefficients
   assign c1 = s1_in_range_ff ? coef : '0;
   assign x1 = sat32(WIDE_W'(s1_prod_ff >>> FRAC_BITS));

   always_ff @(posedge clock) begin
      if (load[1]) begin
         s2_x_ff       <= x1;
         s2_ga_ff      <= 64'(c1.gamma) * 64'(c1.var_inv);
         s2_gm_ff      <= 64'(c1.gamma) * 64'(c1.mean);
         s2_var_inv_ff <= c1.var_inv;
         s2_mean_ff    <= c1.mean;
         s2_beta_ff    <= c1.beta;
         s2_last_ff    <= s1_last_ff;
      end
   end

   // stage 2: fold gamma and beta unless caffe mode
   logic signed [31:0] a2;
   logic signed [31:0] b2;
   logic signed [31:0] s3_x_ff;
   logic signed [31:0] s3_a_ff;
   logic signed [31:0] s3_b_ff;
   logic               s3_last_ff;

   always_comb begin
      if (cfg.caffe_mode) begin
         a2 = s2_var_inv_ff;
         b2 = s2_mean_ff;
      end else begin
         a2 = sat32(WIDE_W'(s2_ga_ff >>> FRAC_BITS));
         b2 = sat32(WIDE_W'(s2_beta_ff) + WIDE_W'(s2_gm_ff >>> FRAC_BITS));
      end
   end

   always_ff @(posedge clock) begin
      if (load[2]) begin
         s3_x_ff    <= s2_x_ff;
         s3_a_ff    <= a2;
         s3_b_ff    <= b2;
         s3_last_ff <= s2_last_ff;
      end
   end

   // stage 3: x times a
   logic signed [63:0] s4_xa_ff;
   logic signed [31:0] s4_b_ff;
   logic               s4_last_ff;

   always_ff @(posedge clock) begin
      if (load[3]) begin
         s4_xa_ff   <= 64'(s3_x_ff) * 64'(s3_a_ff);
         s4_b_ff    <= s3_b_ff;
         s4_last_ff <= s3_last_ff;
      end
   end

   // stage 4: add offset and saturate
   logic signed [31:0] s5_y_ff;
   logic               s5_last_ff;

   always_ff @(posedge clock) begin
      if (load[4]) begin
         s5_y_ff    <= sat32(WIDE_W'(s4_xa_ff >>> FRAC_BITS) + WIDE_W'(s4_b_ff));
         s5_last_ff <= s4_last_ff;
      end
   end

   // stage 5: times reciprocal output scale
   logic signed [64:0] s6_t_ff;
   logic               s6_last_ff;

   always_ff @(posedge clock) begin
      if (load[5]) begin
         s6_t_ff    <= 65'(s5_y_ff) * 65'($signed({1'b0, cfg.output_inv_scale}));
         s6_last_ff <= s5_last_ff;
      end
   end

   // stage 6: add zero point, round half away from zero, clamp to a byte
   logic signed [WIDE_W-1:0] tz;
   logic signed [WIDE_W-1:0] rounded;
   logic [7:0]               value6;
   logic [7:0]               value_ff;
   logic                     last_ff;

   assign tz      = WIDE_W'(s6_t_ff) + $signed(WIDE_W'(cfg.out_zero_pt) << FRAC_BITS);
   assign rounded = (tz + HALF) >>> FRAC_BITS;

   // negative totals round to zero or below, so they clamp to zero
   always_comb begin
      priority if (tz[WIDE_W-1]) begin
         value6 = '0;
      end else if (rounded > WIDE_W'(BYTE_MAX)) begin
         value6 = BYTE_MAX;
      end else begin
         value6 = rounded[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load[6]) begin
         value_ff <= value6;
         last_ff  <= s6_last_ff;
      end
   end

   assign value    = value_ff;
   assign last_out = last_ff;

endmodule

/* design/quantized_batchnorm_uint8.sv */
// A sample beat passes the stage 0 to stage 6 registers before it reaches rsp.
// Throughput: one beat per cycle, loads and samples alike; a waiting result
// stalls only once all seven pipeline registers are full.
// Load beats for channels below MAX_CHANNELS write the coefficient memory at acceptance; no load gives a response.
// Reset clears pipeline valids and sets the control registers to defaults; the coefficient
// memory is not cleared and must be loaded before samples use a channel.
// ----------------------------------------------------------------------------
// quantized_batchnorm_uint8
// Per-channel uint8 batch normalization in Q fixed point, pipelined.
// ----------------------------------------------------------------------------
module quantized_batchnorm_uint8 import qbn_pkg::*; #(
   parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
   parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   qbn_req_if.sink               req_bus,
   qbn_rsp_if.source             rsp_bus,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ADDR_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   // control registers
   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_IN_ZERO_PT:       cfg_in.in_zero_pt       = csr_wdata[7:0];
            CSR_OUT_ZERO_PT:      cfg_in.out_zero_pt      = csr_wdata[7:0];
            CSR_IN_SCALE:         cfg_in.in_scale         = csr_wdata[31:0];
            CSR_OUTPUT_INV_SCALE: cfg_in.output_inv_scale = csr_wdata[31:0];
            CSR_CAFFE_MODE:       cfg_in.caffe_mode       = csr_wdata[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.in_zero_pt       <= '0;
         cfg_ff.out_zero_pt      <= '0;
         cfg_ff.in_scale         <= SCALE_ONE;
         cfg_ff.output_inv_scale <= SCALE_ONE;
         cfg_ff.caffe_mode       <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // request side
   logic              req_fire;
   logic              in_range;
   logic              push;
   logic              coef_wr;
   logic [ADDR_W-1:0] addr;
   logic [STAGES-1:0] load;
   coef_type          coef_wr_data;
   coef_type          coef_rd_data;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign in_range = 32'(req_bus.channel) < 32'(MAX_CHANNELS);
   assign addr     = ADDR_W'(req_bus.channel);
   assign push     = req_fire && (req_bus.mode == MODE_SAMPLE);
   assign coef_wr  = req_fire && (req_bus.mode == MODE_LOAD) && in_range;

   assign coef_wr_data.mean    = req_bus.mean_coef;
   assign coef_wr_data.var_inv = req_bus.var_inv_coef;
   assign coef_wr_data.gamma   = req_bus.gamma_coef;
   assign coef_wr_data.beta    = req_bus.beta_coef;

   assign req_bus.ready = load[0];

   // a load writes at acceptance, so a sample right behind it reads the new entry
   qbn_ram #(
      .WIDTH  ($bits(coef_type)),
      .DEPTH  (MAX_CHANNELS),
      .ADDR_W (ADDR_W)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_wr),
      .wr_addr (addr),
      .wr_data (coef_wr_data),
      .rd_en   (load[0]),
      .rd_addr (addr),
      .rd_data (coef_rd_data)
   );

   qbn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .out_ready (rsp_bus.ready),
      .load      (load),
      .out_valid (rsp_bus.valid)
   );

   qbn_dpath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dpath (
      .clock    (clock),
      .load     (load),
      .cfg      (cfg_ff),
      .sample   (req_bus.sample),
      .last_in  (req_bus.last_in),
      .in_range (in_range),
      .coef     (coef_rd_data),
      .value    (rsp_bus.value),
      .last_out (rsp_bus.last_out)
   );

endmodule
